>>> rtl/sha_pkg.sv
// SHA-256 hasher package: payload types, round constants, initial hash values.
package sha_pkg;

  typedef struct packed {
    logic [7:0] msg_byte;
    logic       byte_present;
    logic       msg_end;
  } in_item_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } out_item_t;

  // controller -> datapath commands
  typedef struct packed {
    logic       buf_we;
    logic [5:0] buf_addr;
    logic [7:0] buf_data;
    logic       load_word;   // shift one buffer byte into the schedule
    logic       round_init;  // copy hash into working vars
    logic       round_en;    // one compression round
    logic       hash_add;    // fold working vars into hash
    logic       hash_reset;  // restore initial values
    logic       shift_out;   // rotate hash words for output
  } sha_cmd_t;

  localparam int unsigned BlockBytes = 64;
  localparam int unsigned Rounds     = 64;
  localparam logic [7:0]  PadByte    = 8'h80;
  localparam logic [5:0]  LenPos     = 6'd56;

  localparam logic [31:0] InitHash [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] RoundK [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

endpackage

>>> rtl/sha_ram.sv
// Generic single-port RAM with registered read.
module sha_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[addr_i] <= wdata_i;
    rdata_o <= mem_q[addr_i];
  end
endmodule

>>> rtl/sha_datapath.sv
// SHA-256 datapath: block buffer, message schedule, round unit, hash state.
module sha_datapath (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  sha_pkg::sha_cmd_t cmd_i,
  input  logic [5:0]        round_i,
  output logic [31:0]       hash_head_o
);
  logic [7:0]  rd_byte;
  logic [31:0] w_q [16];
  logic [31:0] v_q [8];
  logic [31:0] h_q [8];
  logic [31:0] wt, s0, s1, t1, t2, e, a;

  sha_ram #(.Width(8), .Depth(sha_pkg::BlockBytes)) u_buf (
    .clk_i  (clk_i),
    .we_i   (cmd_i.buf_we),
    .addr_i (cmd_i.buf_addr),
    .wdata_i(cmd_i.buf_data),
    .rdata_o(rd_byte)
  );

  // w_q[0] is W[t]; new words appended at 15
  always_comb begin
    s0 = sha_pkg::rotr(w_q[1], 7) ^ sha_pkg::rotr(w_q[1], 18) ^ (w_q[1] >> 3);
    s1 = sha_pkg::rotr(w_q[14], 17) ^ sha_pkg::rotr(w_q[14], 19) ^ (w_q[14] >> 10);
    wt = w_q[0];
    e  = v_q[4];
    a  = v_q[0];
    t1 = v_q[7] + (sha_pkg::rotr(e, 6) ^ sha_pkg::rotr(e, 11) ^ sha_pkg::rotr(e, 25))
         + ((e & v_q[5]) ^ (~e & v_q[6])) + sha_pkg::RoundK[round_i] + wt;
    t2 = (sha_pkg::rotr(a, 2) ^ sha_pkg::rotr(a, 13) ^ sha_pkg::rotr(a, 22))
         + ((a & v_q[1]) ^ (a & v_q[2]) ^ (v_q[1] & v_q[2]));
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_word) begin
      // shift bytes in; 64 loads fill 16 words
      for (int i = 0; i < 15; i++) w_q[i] <= {w_q[i][23:0], w_q[i+1][31:24]};
      w_q[15] <= {w_q[15][23:0], rd_byte};
    end else if (cmd_i.round_en) begin
      for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
      w_q[15] <= s1 + w_q[9] + s0 + w_q[0];
    end
    if (cmd_i.round_init) begin
      for (int i = 0; i < 8; i++) v_q[i] <= h_q[i];
    end else if (cmd_i.round_en) begin
      v_q[7] <= v_q[6];
      v_q[6] <= v_q[5];
      v_q[5] <= v_q[4];
      v_q[4] <= v_q[3] + t1;
      v_q[3] <= v_q[2];
      v_q[2] <= v_q[1];
      v_q[1] <= v_q[0];
      v_q[0] <= t1 + t2;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 8; i++) h_q[i] <= sha_pkg::InitHash[i];
    end else if (cmd_i.hash_reset) begin
      for (int i = 0; i < 8; i++) h_q[i] <= sha_pkg::InitHash[i];
    end else if (cmd_i.hash_add) begin
      for (int i = 0; i < 8; i++) h_q[i] <= h_q[i] + v_q[i];
    end else if (cmd_i.shift_out) begin
      for (int i = 0; i < 7; i++) h_q[i] <= h_q[i+1];
      h_q[7] <= h_q[0];
    end
  end

  assign hash_head_o = h_q[0];
endmodule

>>> rtl/sha_ctrl.sv
// SHA-256 controller: byte intake, padding, round sequencing, digest output.
module sha_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  sha_pkg::in_item_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output sha_pkg::out_item_t out_data_o,
  input  logic [31:0]        hash_head_i,
  output sha_pkg::sha_cmd_t  cmd_o,
  output logic [5:0]         round_o
);
  typedef enum logic [2:0] {
    StIdle, StPad, StLoad, StRound, StAdd, StOut
  } state_e;

  state_e      state_q;
  logic [63:0] len_q;
  logic [5:0]  pad_pos_q;
  logic [6:0]  cnt_q;
  logic        finish_q;   // message end pending
  logic        last_blk_q; // current block is final padded block
  logic        pad_first_q;
  logic [2:0]  widx_q;
  logic        out_vld_q;
  logic        in_fire, out_fire;
  logic [63:0] len_plus;

  assign in_fire  = in_valid_i && in_ready_o;
  assign out_fire = out_valid_o && out_ready_i;
  assign in_ready_o = (state_q == StIdle);
  assign len_plus = len_q + 64'd8;

  // pad byte at pad_pos_q
  logic [7:0] pad_byte;
  always_comb begin
    if (pad_first_q) pad_byte = sha_pkg::PadByte;
    else if (last_blk_q && pad_pos_q >= sha_pkg::LenPos)
      pad_byte = len_q[8'(63 - 8 * (pad_pos_q - sha_pkg::LenPos)) -: 8];
    else pad_byte = 8'h00;
  end

  always_comb begin
    cmd_o = '0;
    round_o = cnt_q[5:0];
    unique case (state_q)
      StIdle: begin
        cmd_o.buf_we   = in_fire && in_data_i.byte_present;
        cmd_o.buf_addr = len_q[8:3];
        cmd_o.buf_data = in_data_i.msg_byte;
      end
      StPad: begin
        cmd_o.buf_we   = 1'b1;
        cmd_o.buf_addr = pad_pos_q;
        cmd_o.buf_data = pad_byte;
      end
      StLoad: begin
        cmd_o.buf_addr   = cnt_q[5:0];
        cmd_o.load_word  = (cnt_q != 7'd0);
        cmd_o.round_init = (cnt_q == 7'd64);
      end
      StRound: cmd_o.round_en = 1'b1;
      StAdd:   cmd_o.hash_add = 1'b1;
      StOut: begin
        cmd_o.shift_out  = out_fire && (widx_q != 3'd7);
        cmd_o.hash_reset = out_fire && (widx_q == 3'd7);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      len_q       <= '0;
      pad_pos_q   <= '0;
      cnt_q       <= '0;
      finish_q    <= 1'b0;
      last_blk_q  <= 1'b0;
      pad_first_q <= 1'b0;
      widx_q      <= '0;
      out_vld_q   <= 1'b0;
    end else begin
      unique case (state_q)
        StIdle: if (in_fire) begin
          finish_q <= in_data_i.msg_end;
          if (in_data_i.byte_present) len_q <= len_plus;
          pad_pos_q   <= in_data_i.byte_present ? len_plus[8:3] : len_q[8:3];
          pad_first_q <= 1'b1;
          last_blk_q  <= 1'b0;
          cnt_q       <= '0;
          if (in_data_i.byte_present && len_plus[8:3] == 6'd0) state_q <= StLoad;
          else if (in_data_i.msg_end) begin
            state_q    <= StPad;
            last_blk_q <= (in_data_i.byte_present ? len_plus[8:3] : len_q[8:3]) < 6'd56;
          end
        end
        StPad: begin
          pad_first_q <= 1'b0;
          pad_pos_q   <= pad_pos_q + 6'd1;
          if (pad_pos_q == 6'd63) state_q <= StLoad;
        end
        StLoad: begin
          cnt_q <= cnt_q + 7'd1;
          if (cnt_q == 7'd64) begin
            cnt_q   <= '0;
            state_q <= StRound;
          end
        end
        StRound: begin
          cnt_q <= cnt_q + 7'd1;
          if (cnt_q == 7'd63) begin
            cnt_q   <= '0;
            state_q <= StAdd;
          end
        end
        StAdd: begin
          if (!finish_q) state_q <= StIdle;
          else if (!last_blk_q) begin
            // another padded block follows
            last_blk_q <= 1'b1;
            pad_pos_q  <= '0;
            state_q    <= StPad;
          end else begin
            state_q    <= StOut;
            widx_q     <= '0;
            out_vld_q  <= 1'b1;
          end
        end
        StOut: begin
          if (!out_vld_q) out_vld_q <= 1'b1;
          else if (out_fire) begin
            out_vld_q <= 1'b0;
            widx_q    <= widx_q + 3'd1;
            if (widx_q == 3'd7) begin
              state_q  <= StIdle;
              finish_q <= 1'b0;
              len_q    <= '0;
            end
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o.digest_word = hash_head_i;
  assign out_data_o.word_index  = widx_q;
  assign out_data_o.last_word   = (widx_q == 3'd7);

  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !in_ready_o) else $error("input taken during output");
  a_len_reset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_fire && widx_q == 3'd7) |=> (len_q == 64'd0)) else $error("length not cleared");
  a_round_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StRound) |-> (cnt_q < 7'd64)) else $error("round count overrun");
endmodule

>>> rtl/sha256_message_hasher.sv
// SHA-256 message hasher top level: controller plus datapath.
// Bytes are written to the block buffer as they arrive; a full block is then
// loaded into the schedule, compressed one round per cycle and folded in.
// On message end the padding pass writes the rest of the buffer,
// one or two blocks are compressed, then eight digest words are output.
// Reset (async, active low) restores the initial hash and zero length.
module sha256_message_hasher (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  sha_pkg::in_item_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output sha_pkg::out_item_t out_data_o
);
  sha_pkg::sha_cmd_t cmd;
  logic [5:0]        round;
  logic [31:0]       hash_head;

  sha_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .in_data_i,
    .out_valid_o, .out_ready_i, .out_data_o,
    .hash_head_i(hash_head), .cmd_o(cmd), .round_o(round)
  );

  sha_datapath u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .round_i(round), .hash_head_o(hash_head)
  );
endmodule
